// ----- sv/olist_pkg.sv -----
// Shared types and constants for the ordered list block.
// No dependencies; imported by the controller, the datapath and the top level.
package olist_pkg;

    localparam int KIND_W = 2;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;

    // operation requested by an input item
    typedef enum logic [KIND_W-1:0] {
        K_INSERT = 2'd0,
        K_DELETE = 2'd1,
        K_FIND   = 2'd2,
        K_READ   = 2'd3
    } kind_t;

    // result status code
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic setup;
        logic walk;
        logic finish;
        logic emit;
    } ol_cmd_t;

    // datapath to controller status
    typedef struct packed {
        status_t chk;
        logic    no_walk;
        logic    at_end;
        logic    match;
        logic    out_free;
    } ol_sts_t;

endpackage

// ----- sv/olist_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module olist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/olist_ctrl.sv -----
// Controller state machine for the ordered list block.
// Depends on olist_pkg; drives commands into olist_dp and reads its status.
module olist_ctrl
    import olist_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  ol_sts_t sts,
    output ol_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_DRAIN,
        S_FINISH,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (sts.chk != ST_OK)
                begin
                    state_next = S_DONE;
                end
                else if (sts.no_walk)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.match)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.at_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands decoded from state
    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        cmd.setup  = (state_reg == S_START);
        cmd.walk   = (state_reg == S_WALK);
        cmd.finish = (state_reg == S_FINISH);
        cmd.emit   = (state_reg == S_DONE) && sts.out_free;
    end

    assign in_stall = (state_reg != S_IDLE);

    // the last read always comes back before the finishing step
    a_drain_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |=> (state_reg == S_FINISH))
        else $error("drain not followed by finish");

    // a failed check goes straight to the result
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START && sts.chk != ST_OK) |=> (state_reg == S_DONE))
        else $error("failed check did not go to result");

    // a blocked result holds the controller
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !sts.out_free) |=> (state_reg == S_DONE))
        else $error("result dropped while output blocked");

endmodule

// ----- sv/olist_dp.sv -----
// Datapath for the ordered list block: element memory, count, walk index,
// result and output registers. Depends on olist_pkg and olist_ram.
module olist_dp
    import olist_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ol_cmd_t           cmd,
    output ol_sts_t           sts,
    input  logic [KIND_W-1:0] kind,
    input  logic [POS_W-1:0]  position,
    input  logic [DATA_W-1:0] value,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [1:0]        status,
    output logic [DATA_W-1:0] item_value,
    output logic [POS_W-1:0]  found_position,
    output logic [POS_W-1:0]  list_length
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

    // latched item
    kind_t             kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;

    // list state and walk
    logic [CW-1:0]     cnt_reg;
    logic [AW-1:0]     idx_reg;
    logic [AW-1:0]     end_reg;
    logic              desc_reg;
    logic              rd_vld_reg;
    logic [AW-1:0]     rd_addr_reg;

    // result
    logic [DATA_W-1:0] item_reg;
    logic [POS_W-1:0]  found_reg;
    logic              hit_reg;
    status_t           st_reg;

    // output stage
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [DATA_W-1:0] out_item_reg;
    logic [POS_W-1:0]  out_found_reg;
    logic [POS_W-1:0]  out_len_reg;

    // memory ports
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rd_data;

    // widened copies for compares
    logic [WW-1:0]     pos_w;
    logic [WW-1:0]     cnt_w;
    logic [WW-1:0]     cap_w;
    logic [WW-1:0]     pm1_w;
    logic [WW-1:0]     cm1_w;
    logic [WW-1:0]     found_w;
    logic [AW-1:0]     pm1_a;
    logic [AW-1:0]     cm1_a;
    logic              at_end;
    logic              match;
    logic              first_rd;
    logic              out_free;
    status_t           chk;
    logic              no_walk;

    assign pos_w   = WW'(pos_reg);
    assign cnt_w   = WW'(cnt_reg);
    assign cap_w   = WW'(CAPACITY);
    assign pm1_w   = pos_w - WW'(1);
    assign cm1_w   = cnt_w - WW'(1);
    assign pm1_a   = pm1_w[AW-1:0];
    assign cm1_a   = cm1_w[AW-1:0];
    assign found_w = WW'(rd_addr_reg) + WW'(1);

    assign at_end   = (idx_reg == end_reg);
    assign match    = rd_vld_reg && (kind_reg == K_FIND) && (rd_data == val_reg) && !hit_reg;
    assign first_rd = (rd_addr_reg == pm1_a);
    assign out_free = !out_valid_reg || !out_stall;

    // position and capacity checks on the latched item
    always_comb
    begin
        chk     = ST_OK;
        no_walk = 1'b0;
        case (kind_reg)
            K_INSERT:
            begin
                if (pos_reg == '0 || pos_w > cnt_w + WW'(1))
                begin
                    chk = ST_RANGE;
                end
                else if (cnt_w == cap_w)
                begin
                    chk = ST_FULL;
                end
                no_walk = (pos_w == cnt_w + WW'(1));
            end
            K_DELETE, K_READ:
            begin
                if (pos_reg == '0 || pos_w > cnt_w)
                begin
                    chk = ST_RANGE;
                end
            end
            K_FIND:
            begin
                if (cnt_reg == '0)
                begin
                    chk = ST_NOTFOUND;
                end
            end
            default:
            begin
                chk = ST_OK;
            end
        endcase
    end

    // memory write: shift step on returned data, or the new value at the end of insert
    always_comb
    begin
        we    = 1'b0;
        waddr = rd_addr_reg;
        wdata = rd_data;
        if (cmd.finish && kind_reg == K_INSERT)
        begin
            we    = 1'b1;
            waddr = pm1_a;
            wdata = val_reg;
        end
        else if (rd_vld_reg && kind_reg == K_INSERT)
        begin
            we    = 1'b1;
            waddr = rd_addr_reg + AW'(1);
        end
        else if (rd_vld_reg && kind_reg == K_DELETE && !first_rd)
        begin
            we    = 1'b1;
            waddr = rd_addr_reg - AW'(1);
        end
    end

    olist_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(idx_reg),
        .rdata(rd_data)
    );

    // item capture, walk control and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind_t'(kind);
            pos_reg  <= position;
            val_reg  <= value;
        end

        if (cmd.setup)
        begin
            st_reg    <= chk;
            item_reg  <= '0;
            found_reg <= '0;
            hit_reg   <= 1'b0;
            case (kind_reg)
                K_INSERT:
                begin
                    idx_reg  <= cm1_a;
                    end_reg  <= pm1_a;
                    desc_reg <= 1'b1;
                end
                K_DELETE:
                begin
                    idx_reg  <= pm1_a;
                    end_reg  <= cm1_a;
                    desc_reg <= 1'b0;
                end
                K_FIND:
                begin
                    idx_reg  <= '0;
                    end_reg  <= cm1_a;
                    desc_reg <= 1'b0;
                end
                default:
                begin
                    idx_reg  <= pm1_a;
                    end_reg  <= pm1_a;
                    desc_reg <= 1'b0;
                end
            endcase
        end
        else
        begin
            if (cmd.walk && !at_end)
            begin
                idx_reg <= desc_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
            end
            if (rd_vld_reg && (kind_reg == K_READ || (kind_reg == K_DELETE && first_rd)))
            begin
                item_reg <= rd_data;
            end
            if (match)
            begin
                found_reg <= found_w[POS_W-1:0];
                hit_reg   <= 1'b1;
            end
            if (cmd.finish && kind_reg == K_FIND)
            begin
                st_reg <= hit_reg ? ST_OK : ST_NOTFOUND;
            end
        end

        rd_addr_reg <= idx_reg;

        if (cmd.emit)
        begin
            out_status_reg <= st_reg;
            out_item_reg   <= item_reg;
            out_found_reg  <= found_reg;
            out_len_reg    <= cnt_w[POS_W-1:0];
        end
    end

    // control registers: count, read-return flag, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.walk;
            if (cmd.finish && kind_reg == K_INSERT)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (cmd.finish && kind_reg == K_DELETE)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status to controller
    always_comb
    begin
        sts.chk      = chk;
        sts.no_walk  = no_walk;
        sts.at_end   = at_end;
        sts.match    = match;
        sts.out_free = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign item_value     = out_item_reg;
    assign found_position = out_found_reg;
    assign list_length    = out_len_reg;

    // length never beyond capacity
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_w <= cap_w)
        else $error("list length above capacity");

    // an insert only completes into a list with room
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && kind_reg == K_INSERT) |-> (cnt_w < cap_w))
        else $error("insert completed into full list");

    // writes stay inside the used part of the list plus one
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (WW'(waddr) <= cnt_w))
        else $error("memory write beyond list end");

endmodule

// ----- sv/ordered_list_insert_delete_search.sv -----
// Positional list of signed 32-bit words in one RAM of CAPACITY entries.
// An item is accepted, checked, walks the RAM one entry a cycle, then finishes and
// loads its result; insert and delete walk n-p+1 entries, find to the first match or n,
// read one; append skips the walk, and a rejected item goes straight to the result.
// One item at a time: the next is taken in the cycle after the result is loaded.
// Reset clears the length and control state; the RAM is not cleared.
module ordered_list_insert_delete_search
    import olist_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KIND_W-1:0] kind,
    input  logic [POS_W-1:0]  position,
    input  logic [DATA_W-1:0] value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [DATA_W-1:0] item_value,
    output logic [POS_W-1:0]  found_position,
    output logic [POS_W-1:0]  list_length
);

    ol_cmd_t cmd;
    ol_sts_t sts;

    // sequencing
    olist_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage and result path
    olist_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .position      (position),
        .value         (value),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .item_value    (item_value),
        .found_position(found_position),
        .list_length   (list_length)
    );

endmodule
